FILE: rtl/core/record_container_check_extract_assert.svh
// Assertion macros used by the port checker file of the container checker.
// Each macro states one property, clocked on clk and disabled while arst_n is low.
`ifndef RECORD_CONTAINER_CHECK_EXTRACT_ASSERT_SVH
`define RECORD_CONTAINER_CHECK_EXTRACT_ASSERT_SVH

// Same-cycle implication.
`define RCCE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("container check assertion failed");

// Next-cycle implication.
`define RCCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("container check assertion failed");

`endif

FILE: rtl/core/rcce_pkg.sv
// ----------------------------------------------------------------------------
// rcce_pkg
// Types and constants of the record container checker and region extractor.
// ----------------------------------------------------------------------------
package rcce_pkg;

	localparam logic [31:0] FILE_ID_VALUE = 32'h7247_704B;
	localparam logic [7:0]  TYPE_DATA_VERSION = 8'h44;
	localparam logic [7:0]  TYPE_APP_VERSION  = 8'h41;
	localparam logic [7:0]  TYPE_REGION       = 8'h52;

	// Bit positions in error_flags.
	localparam int ERR_ID             = 0;
	localparam int ERR_TYPE           = 1;
	localparam int ERR_UNTERM         = 2;
	localparam int ERR_NO_D           = 3;
	localparam int ERR_MANY_D         = 4;
	localparam int ERR_FIRST_NOT_D    = 5;
	localparam int ERR_NO_A           = 6;
	localparam int ERR_TRUNC          = 7;
	localparam int ERR_REGION_MISSING = 8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        done_res;
		logic        file_ok;
		logic [8:0]  error_flags;
		logic [15:0] region_total;
	} res_t;

endpackage

FILE: rtl/core/rcce_parser.sv
// ----------------------------------------------------------------------------
// rcce_parser
// Framing state machine: walks the stream one byte per step, keeps the record
// counters and the region register, and forms the result word of each step.
// ----------------------------------------------------------------------------
module rcce_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            fire,
	input  rcce_pkg::item_t item,
	output rcce_pkg::res_t  res
);
	import rcce_pkg::*;

	localparam logic [2:0] PH_ID            = 3'd0;
	localparam logic [2:0] PH_VERSION       = 3'd1;
	localparam logic [2:0] PH_HEADER        = 3'd2;
	localparam logic [2:0] PH_SKIP          = 3'd3;
	localparam logic [2:0] PH_REGION_HEADER = 3'd4;
	localparam logic [2:0] PH_REGION_BODY   = 3'd5;
	localparam logic [2:0] PH_IGNORE        = 3'd6;

	logic [15:0] extract_q;
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  fidx_q, fidx_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] remain_q, remain_d;
	logic [7:0]  kind_q, kind_d;
	logic [1:0]  dv_cnt_q, dv_cnt_d;
	logic        av_q, av_d;
	logic [15:0] region_cnt_q, region_cnt_d;
	logic        any_q, any_d;
	logic        first_d_q, first_d_d;
	logic        pending_q, pending_d;
	logic [2:0]  err_q, err_d;

	logic [7:0]  b;
	logic [1:0]  byte_pos;
	logic [31:0] shift_ins;
	logic [31:0] remain_dec;
	logic [3:0]  rh_pos;
	logic [15:0] region_inc;
	logic [8:0]  flags;

	assign b          = item.data_byte;
	assign remain_dec = remain_q - 32'd1;
	assign rh_pos     = fidx_q - 4'd6;
	assign region_inc = (region_cnt_q != 16'hFFFF) ? region_cnt_q + 16'd1 : region_cnt_q;
	assign byte_pos   = (phase_q == PH_REGION_HEADER) ? rh_pos[1:0] : fidx_q[1:0];
	assign shift_ins  = shift_q | ({24'd0, b} << {byte_pos, 3'b000});

	always_comb begin
		phase_d      = phase_q;
		fidx_d       = fidx_q;
		shift_d      = shift_q;
		remain_d     = remain_q;
		kind_d       = kind_q;
		dv_cnt_d     = dv_cnt_q;
		av_d         = av_q;
		region_cnt_d = region_cnt_q;
		any_d        = any_q;
		first_d_d    = first_d_q;
		pending_d    = pending_q;
		err_d        = err_q;
		flags        = '0;
		res          = '0;

		if (item.end_of_stream) begin
			flags[2:0] = err_q;
			flags[ERR_TRUNC] = (phase_q == PH_ID) || (phase_q == PH_VERSION) ||
				(phase_q == PH_SKIP) || (phase_q == PH_REGION_HEADER) ||
				((phase_q == PH_HEADER) && (fidx_q != 4'd0));
			flags[ERR_NO_D]           = (dv_cnt_q == 2'd0);
			flags[ERR_MANY_D]         = (dv_cnt_q > 2'd1);
			flags[ERR_FIRST_NOT_D]    = any_q && !first_d_q;
			flags[ERR_NO_A]           = !av_q;
			flags[ERR_REGION_MISSING] = pending_q;
			res.done_res     = 1'b1;
			res.file_ok      = (flags[7:0] == 8'd0);
			res.error_flags  = flags;
			res.region_total = region_cnt_q;
			// The next byte opens a new stream.
			phase_d      = PH_ID;
			fidx_d       = '0;
			shift_d      = '0;
			remain_d     = '0;
			kind_d       = '0;
			dv_cnt_d     = '0;
			av_d         = 1'b0;
			region_cnt_d = '0;
			any_d        = 1'b0;
			first_d_d    = 1'b0;
			pending_d    = (extract_q != 16'd0);
			err_d        = '0;
		end else begin
			unique case (phase_q)
				PH_ID: begin
					shift_d = shift_ins;
					fidx_d  = fidx_q + 4'd1;
					if (fidx_q == 4'd3) begin
						if (shift_ins != FILE_ID_VALUE) err_d[ERR_ID] = 1'b1;
						phase_d = PH_VERSION;
						fidx_d  = '0;
						shift_d = '0;
					end
				end
				PH_VERSION: begin
					fidx_d = fidx_q + 4'd1;
					if (fidx_q == 4'd1) begin
						phase_d = PH_HEADER;
						fidx_d  = '0;
						shift_d = '0;
					end
				end
				PH_HEADER: begin
					if (fidx_q < 4'd4) begin
						shift_d = shift_ins;
						fidx_d  = fidx_q + 4'd1;
					end else if (b == TYPE_DATA_VERSION) begin
						if (dv_cnt_q != 2'd3) dv_cnt_d = dv_cnt_q + 2'd1;
						first_d_d = !any_q;
						any_d     = 1'b1;
						kind_d    = b;
						remain_d  = shift_q;
						if (shift_q == 32'd0) begin
							phase_d = PH_HEADER;
							fidx_d  = '0;
						end else begin
							phase_d = PH_SKIP;
						end
					end else if (b == TYPE_APP_VERSION) begin
						av_d  = 1'b1;
						any_d = 1'b1;
						if (shift_q == 32'd0) begin
							err_d[ERR_UNTERM] = 1'b1;
							phase_d = PH_HEADER;
							fidx_d  = '0;
						end else begin
							kind_d   = b;
							remain_d = shift_q;
							phase_d  = PH_SKIP;
						end
					end else if (b == TYPE_REGION) begin
						any_d   = 1'b1;
						phase_d = PH_REGION_HEADER;
						fidx_d  = '0;
						shift_d = '0;
					end else begin
						err_d[ERR_TYPE] = 1'b1;
						phase_d = PH_IGNORE;
					end
				end
				PH_SKIP: begin
					remain_d = remain_dec;
					if (remain_dec == 32'd0) begin
						// The last body byte of an app-version record must be a terminator.
						if (kind_q == TYPE_APP_VERSION && b != 8'd0) err_d[ERR_UNTERM] = 1'b1;
						phase_d = PH_HEADER;
						fidx_d  = '0;
						shift_d = '0;
					end
				end
				PH_REGION_HEADER: begin
					// Only the payload length, header bytes six to nine, is kept.
					if (fidx_q >= 4'd6) shift_d = shift_ins;
					fidx_d = fidx_q + 4'd1;
					if (fidx_q == 4'd9) begin
						region_cnt_d = region_inc;
						kind_d       = 8'd0;
						if (pending_q && region_inc == extract_q) begin
							pending_d = 1'b0;
							kind_d    = 8'd1;
						end
						remain_d = shift_d;
						if (shift_d == 32'd0) begin
							phase_d = PH_HEADER;
							fidx_d  = '0;
							shift_d = '0;
						end else begin
							phase_d = PH_REGION_BODY;
						end
					end
				end
				PH_REGION_BODY: begin
					if (kind_q == 8'd1) begin
						res.payload_byte  = b;
						res.payload_valid = 1'b1;
					end
					remain_d = remain_dec;
					if (remain_dec == 32'd0) begin
						phase_d = PH_HEADER;
						fidx_d  = '0;
						shift_d = '0;
					end
				end
				default: begin
				end
			endcase
			flags[2:0]       = err_d;
			res.file_ok      = (flags == 9'd0);
			res.error_flags  = flags;
			res.region_total = region_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extract_q    <= '0;
			phase_q      <= PH_ID;
			fidx_q       <= '0;
			shift_q      <= '0;
			remain_q     <= '0;
			kind_q       <= '0;
			dv_cnt_q     <= '0;
			av_q         <= 1'b0;
			region_cnt_q <= '0;
			any_q        <= 1'b0;
			first_d_q    <= 1'b0;
			pending_q    <= 1'b0;
			err_q        <= '0;
		end else begin
			if (cfg_we) extract_q <= cfg_wdata;
			if (fire) begin
				phase_q      <= phase_d;
				fidx_q       <= fidx_d;
				shift_q      <= shift_d;
				remain_q     <= remain_d;
				kind_q       <= kind_d;
				dv_cnt_q     <= dv_cnt_d;
				av_q         <= av_d;
				region_cnt_q <= region_cnt_d;
				any_q        <= any_d;
				first_d_q    <= first_d_d;
				err_q        <= err_d;
			end
			// A register write rearms the region request.
			if (cfg_we) pending_q <= (cfg_wdata != 16'd0);
			else if (fire) pending_q <= pending_d;
		end
	end

endmodule

FILE: rtl/core/record_container_check_extract.sv
// ----------------------------------------------------------------------------
// record_container_check_extract
// Record container checker and region payload extractor, top level.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid, item_stall, item_word) carries one stream byte
// per word, or an end-of-stream word that asks for the final status. The
// result channel (res_valid, res_stall, res_word) returns exactly one word for
// every item word: a payload byte of the selected region when there is one,
// the running error bits, and on the end word the full error flags.
// cfg_we with cfg_wdata writes the region to extract; write it while idle.
// An item word is registered at acceptance, and its result is registered
// in the result register once that register is free. One word is taken
// in every cycle while the result side keeps up. When the
// receiver stalls, the result register holds its word and the input register
// holds the next one; item_stall then rises until the result side drains.
// Reset empties both registers and clears the parse state and the region
// register; the block then waits for the file ID of a new stream. After an
// end word the parse state returns to that point and the region is kept.
// ----------------------------------------------------------------------------
module record_container_check_extract (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            item_valid,
	output logic            item_stall,
	input  rcce_pkg::item_t item_word,
	output logic            res_valid,
	input  logic            res_stall,
	output rcce_pkg::res_t  res_word
);
	import rcce_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	res_t  res_q;
	logic  res_valid_q;
	res_t  res_next;
	logic  res_free;
	logic  fire;
	logic  take;

	assign res_free   = !res_valid_q || !res_stall;
	assign fire       = valid_s1 && res_free;
	assign item_stall = valid_s1 && !res_free;
	assign take       = item_valid && !item_stall;

	rcce_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= take || (valid_s1 && !fire);
			res_valid_q <= fire || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_s1 <= item_word;
		if (fire) res_q <= res_next;
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

FILE: rtl/core/rcce_checker.sv
// ----------------------------------------------------------------------------
// rcce_checker
// Port-level assertions on the result channel of the container checker.
// ----------------------------------------------------------------------------
`include "record_container_check_extract_assert.svh"

module rcce_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input rcce_pkg::res_t res_word
);
	import rcce_pkg::*;

	// A stalled result word stays in place.
	`RCCE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))
	// The end word never carries payload.
	`RCCE_ASSERT_NOW(a_done_no_payload, res_valid && res_word.done_res, !res_word.payload_valid)
	// Without a payload the byte field is zero.
	`RCCE_ASSERT_NOW(a_idle_byte, res_valid && !res_word.payload_valid, res_word.payload_byte == 8'd0)
	// The summary bit agrees with the format error bits.
	`RCCE_ASSERT_NOW(a_ok_flags, res_valid, res_word.file_ok == (res_word.error_flags[7:0] == 8'd0))

endmodule

bind record_container_check_extract rcce_checker u_rcce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);

FILE: dv/rcce_stream_checker.sv
// ----------------------------------------------------------------------------
// rcce_stream_checker
// Watches the item, result and register ports of the container checker. It
// keeps its own copy of the record walk, predicts one result word for every
// accepted item word and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module rcce_stream_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            item_valid,
	input  logic            item_stall,
	input  rcce_pkg::item_t item_word,
	input  logic            res_valid,
	input  logic            res_stall,
	input  rcce_pkg::res_t  res_word,
	output int              errors
);
	import rcce_pkg::*;

	typedef enum logic [3:0] {
		W_ID,
		W_VERSION,
		W_HEADER,
		W_SKIP,
		W_REGION_HDR,
		W_REGION_BODY,
		W_IGNORE
	} walk_t;

	localparam logic [8:0] RUNNING_MASK = (9'd1 << ERR_ID) | (9'd1 << ERR_TYPE) |
		(9'd1 << ERR_UNTERM) | (9'd1 << ERR_TRUNC);

	walk_t       walk;
	logic [3:0]  byte_pos;
	logic [31:0] field_acc;
	logic [31:0] left_count;
	logic        skip_is_app;
	logic        emit_payload;
	logic [1:0]  d_records;
	logic        a_seen;
	logic [15:0] region_num;
	logic        any_record;
	logic        d_came_first;
	logic        region_wanted;
	logic [8:0]  err_run;
	logic [15:0] region_sel;

	res_t expected_q[$];
	int   mismatches;

	function automatic void restart_walk();
		walk = W_ID;
		byte_pos = '0;
		field_acc = '0;
		left_count = '0;
		skip_is_app = 1'b0;
		emit_payload = 1'b0;
		d_records = '0;
		a_seen = 1'b0;
		region_num = '0;
		any_record = 1'b0;
		d_came_first = 1'b0;
		region_wanted = (region_sel != '0);
		err_run = '0;
	endfunction

	function automatic void open_header();
		walk = W_HEADER;
		byte_pos = '0;
		field_acc = '0;
	endfunction

	function automatic void begin_skip(input logic is_app);
		skip_is_app = is_app;
		left_count = field_acc;
		if (left_count == '0)
			open_header();
		else
			walk = W_SKIP;
	endfunction

	// The type byte of a record header decides how its body is walked.
	function automatic void take_type(input logic [7:0] kind);
		if (kind == TYPE_DATA_VERSION) begin
			if (d_records != 2'd3)
				d_records++;
			d_came_first = !any_record;
			any_record = 1'b1;
			begin_skip(1'b0);
		end else if (kind == TYPE_APP_VERSION) begin
			a_seen = 1'b1;
			any_record = 1'b1;
			if (field_acc == '0) begin
				err_run[ERR_UNTERM] = 1'b1;
				open_header();
			end else begin
				begin_skip(1'b1);
			end
		end else if (kind == TYPE_REGION) begin
			any_record = 1'b1;
			walk = W_REGION_HDR;
			byte_pos = '0;
			field_acc = '0;
		end else begin
			err_run[ERR_TYPE] = 1'b1;
			walk = W_IGNORE;
		end
	endfunction

	function automatic res_t walk_word(input item_t w);
		res_t r;
		logic [8:0] flags;
		r = '0;
		if (w.end_of_stream) begin
			flags = err_run;
			if (walk == W_ID || walk == W_VERSION || walk == W_SKIP || walk == W_REGION_HDR ||
					(walk == W_HEADER && byte_pos != '0))
				flags[ERR_TRUNC] = 1'b1;
			if (d_records == 2'd0)
				flags[ERR_NO_D] = 1'b1;
			if (d_records > 2'd1)
				flags[ERR_MANY_D] = 1'b1;
			if (any_record && !d_came_first)
				flags[ERR_FIRST_NOT_D] = 1'b1;
			if (!a_seen)
				flags[ERR_NO_A] = 1'b1;
			if (region_wanted)
				flags[ERR_REGION_MISSING] = 1'b1;
			r.done_res = 1'b1;
			r.file_ok = (flags[7:0] == '0);
			r.error_flags = flags;
			r.region_total = region_num;
			restart_walk();
			return r;
		end

		case (walk)
			W_ID: begin
				field_acc[8*byte_pos +: 8] = w.data_byte;
				byte_pos++;
				if (byte_pos == 4'd4) begin
					if (field_acc != FILE_ID_VALUE)
						err_run[ERR_ID] = 1'b1;
					walk = W_VERSION;
					byte_pos = '0;
					field_acc = '0;
				end
			end
			W_VERSION: begin
				byte_pos++;
				if (byte_pos == 4'd2)
					open_header();
			end
			W_HEADER: begin
				if (byte_pos < 4'd4) begin
					field_acc[8*byte_pos +: 8] = w.data_byte;
					byte_pos++;
				end else begin
					take_type(w.data_byte);
				end
			end
			W_SKIP: begin
				left_count--;
				if (left_count == '0) begin
					// An app record must end on a zero byte.
					if (skip_is_app && w.data_byte != 8'h00)
						err_run[ERR_UNTERM] = 1'b1;
					open_header();
				end
			end
			W_REGION_HDR: begin
				// Only the last four header bytes, the payload length, are kept.
				if (byte_pos >= 4'd6)
					field_acc[8*(byte_pos - 6) +: 8] = w.data_byte;
				byte_pos++;
				if (byte_pos == 4'd10) begin
					if (region_num != 16'hFFFF)
						region_num++;
					emit_payload = 1'b0;
					if (region_wanted && region_num == region_sel) begin
						region_wanted = 1'b0;
						emit_payload = 1'b1;
					end
					left_count = field_acc;
					if (left_count == '0)
						open_header();
					else
						walk = W_REGION_BODY;
				end
			end
			W_REGION_BODY: begin
				if (emit_payload) begin
					r.payload_byte = w.data_byte;
					r.payload_valid = 1'b1;
				end
				left_count--;
				if (left_count == '0)
					open_header();
			end
			default: begin
			end
		endcase

		flags = err_run & RUNNING_MASK;
		r.file_ok = (flags == '0);
		r.error_flags = flags;
		r.region_total = region_num;
		return r;
	endfunction

	function automatic void compare_word(input res_t got);
		res_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected word: byte %02h valid %b done %b ok %b flags %03h rg %0d",
					$realtime, got.payload_byte, got.payload_valid, got.done_res,
					got.file_ok, got.error_flags, got.region_total);
			return;
		end
		want = expected_q.pop_front();
		if (got.payload_byte !== want.payload_byte || got.payload_valid !== want.payload_valid ||
				got.done_res !== want.done_res || got.file_ok !== want.file_ok ||
				got.error_flags !== want.error_flags ||
				got.region_total !== want.region_total) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: result mismatch", $realtime);
				$display("  expected byte %02h valid %b done %b ok %b flags %03h regions %0d",
					want.payload_byte, want.payload_valid, want.done_res, want.file_ok,
					want.error_flags, want.region_total);
				$display("  actual   byte %02h valid %b done %b ok %b flags %03h regions %0d",
					got.payload_byte, got.payload_valid, got.done_res, got.file_ok,
					got.error_flags, got.region_total);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_sel = '0;
			restart_walk();
			expected_q.delete();
			mismatches = 0;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				region_sel = cfg_wdata;
				region_wanted = (cfg_wdata != '0);
			end
			if (item_valid && !item_stall)
				expected_q.push_back(walk_word(item_word));
			if (res_valid && !res_stall)
				compare_word(res_word);
			// Words still waiting count against the run as well.
			errors <= mismatches + expected_q.size();
		end
	end

endmodule

FILE: dv/tb_record_container_check_extract.sv
// ----------------------------------------------------------------------------
// tb_record_container_check_extract
// Feeds the container checker with short directed streams, then random
// containers under several region selections, one stream at full rate on
// both sides, and one long result stall. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_record_container_check_extract;
	import rcce_pkg::*;

	localparam int QUIET_LIMIT       = 1000;
	localparam int HOLD_CYCLES       = 80;
	localparam int DRAIN_CYCLES      = 8;
	localparam int PHASE_WORDS       = 80;
	localparam int FULL_RATE_REGIONS = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        item_valid;
	logic        item_stall;
	item_t       item_word;
	logic        res_valid;
	logic        res_stall;
	res_t        res_word;

	int errors;
	int items_sent = 0;
	int results_seen = 0;
	int cut_left = -1;
	bit idle_on;
	bit hold_armed;

	record_container_check_extract u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_word  (item_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word)
	);

	rcce_stream_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_word  (item_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word),
		.errors     (errors)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall)
			results_seen <= results_seen + 1;
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin : result_sink
		bit hold_done;
		hold_done = 1'b0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= idle_on && ($urandom_range(99) < 13);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_record_container_check_extract: errors");
		$finish;
	end

	task automatic put_word(input logic [7:0] b, input logic eos);
		while (idle_on && $urandom_range(99) < 13) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_word <= '{data_byte: b, end_of_stream: eos};
		do
			@(posedge clk);
		while (item_stall);
		items_sent++;
	endtask

	// Stream bytes past the cut point are dropped, which truncates the container.
	task automatic stream_byte(input logic [7:0] b);
		if (cut_left == 0)
			return;
		if (cut_left > 0)
			cut_left--;
		put_word(b, 1'b0);
	endtask

	task automatic put_le(input logic [31:0] value, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			stream_byte(value[8*i +: 8]);
	endtask

	task automatic end_stream();
		cut_left = -1;
		put_word(8'($urandom), 1'b1);
	endtask

	task automatic put_head(input bit good_id);
		logic [31:0] id;
		id = good_id ? FILE_ID_VALUE : (FILE_ID_VALUE ^ (32'd1 << $urandom_range(31)));
		put_le(id, 4);
		put_le($urandom, 2);
	endtask

	task automatic put_data_record();
		logic [31:0] size;
		size = ($urandom_range(99) < 4) ? 32'($urandom) : 32'($urandom_range(6));
		put_le(size, 4);
		stream_byte(TYPE_DATA_VERSION);
		// A huge size swallows the rest of the container.
		repeat ((size > 6) ? 6 : size)
			stream_byte(8'($urandom));
	endtask

	task automatic put_app_record();
		int size;
		size = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 6);
		put_le(size, 4);
		stream_byte(TYPE_APP_VERSION);
		for (int i = 0; i < size; i++) begin
			if (i == size - 1 && $urandom_range(99) < 75)
				stream_byte(8'h00);
			else
				stream_byte(8'($urandom));
		end
	endtask

	task automatic put_region(input int len);
		put_le($urandom, 4);
		stream_byte(TYPE_REGION);
		put_le($urandom, 2);
		put_le($urandom, 4);
		put_le(len, 4);
		repeat (len)
			stream_byte(8'($urandom));
	endtask

	task automatic put_odd_record();
		logic [7:0] kind;
		do
			kind = 8'($urandom);
		while (kind == TYPE_DATA_VERSION || kind == TYPE_APP_VERSION || kind == TYPE_REGION);
		put_le($urandom_range(8), 4);
		stream_byte(kind);
		repeat ($urandom_range(6))
			stream_byte(8'($urandom));
	endtask

	task automatic send_container();
		int shape;
		shape = $urandom_range(99);
		cut_left = ($urandom_range(99) < 10) ? int'($urandom_range(40)) : -1;
		if (shape < 6) begin
			repeat ($urandom_range(10))
				stream_byte(8'($urandom));
		end else begin
			put_head($urandom_range(99) >= 6);
			if (shape < 12)
				put_app_record();
			if (shape % 10 != 3)
				put_data_record();
			if (shape % 9 == 4)
				put_data_record();
			if (shape % 11 != 5)
				put_app_record();
			if (shape >= 94)
				put_odd_record();
			repeat ($urandom_range(4))
				put_region(($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(9, 40));
		end
		end_stream();
	endtask

	task automatic wait_drained();
		while (results_seen != items_sent)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_region(input logic [15:0] sel);
		item_valid <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= sel;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [15:0] sel;
		int          phase_start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_valid <= 1'b0;
		item_word <= '0;
		idle_on <= 1'b1;
		hold_armed <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End word on an empty stream, then the smallest well-formed container.
		end_stream();
		put_le(FILE_ID_VALUE, 4);
		put_le(32'h0000_FFFF, 2);
		put_le(0, 4);
		stream_byte(TYPE_DATA_VERSION);
		put_le(1, 4);
		stream_byte(TYPE_APP_VERSION);
		stream_byte(8'h00);
		put_word(8'hFF, 1'b1);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: sel = 16'd1;
				1: sel = 16'd2;
				2: sel = 16'd0;
				3: sel = 16'd3;
				4: sel = 16'($urandom_range(1, 4));
				default: sel = 16'($urandom_range(16'h8000, 16'hFFFE));
			endcase
			set_region(sel);
			if (p == 1)
				hold_armed <= 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_WORDS)
				send_container();
		end

		// One stream with no idling on either side; the last region is extracted.
		idle_on <= 1'b0;
		set_region(16'(FULL_RATE_REGIONS));
		put_le(FILE_ID_VALUE, 4);
		put_le($urandom, 2);
		put_le(0, 4);
		stream_byte(TYPE_DATA_VERSION);
		put_le(1, 4);
		stream_byte(TYPE_APP_VERSION);
		stream_byte(8'h00);
		for (int r = 1; r <= FULL_RATE_REGIONS; r++)
			put_region((r == FULL_RATE_REGIONS) ? 3 : r % 3);
		end_stream();

		idle_on <= 1'b1;
		set_region(16'd1);
		repeat (3)
			send_container();

		item_valid <= 1'b0;
		wait_drained();
		if (errors == 0)
			$display("tb_record_container_check_extract: clean");
		else
			$display("tb_record_container_check_extract: errors");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rcce_pkg.sv
rtl/core/rcce_parser.sv
rtl/core/record_container_check_extract.sv
rtl/core/rcce_checker.sv
dv/rcce_stream_checker.sv
dv/tb_record_container_check_extract.sv
